### hw/rtl/acl_pkg.sv
// Shared constants, the CORDIC cell record and the arctangent table.
// Used by the top level, the CORDIC cell and the testbench of the astroid point and arc length core.
package acl_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int CW            = 34;
    localparam int PHASE_W       = ANGLE_BITS - 2;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_CENTER_X = 2'd1;
    localparam logic [1:0] REG_CENTER_Y = 2'd2;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [CW-1:0] GAIN_Q30  = CW'(652032874);
    localparam logic [CW-1:0] ONE_Q30   = CW'(1073741824);

    typedef struct packed {
        logic                 valid;
        logic [1:0]           quad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cell_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [STAGE_W-1:0] i);
        logic signed [CW-1:0] r;
        unique case (i)
            STAGE_W'(0): r = CW'(843314857);
            STAGE_W'(1): r = CW'(497837829);
            STAGE_W'(2): r = CW'(263043837);
            STAGE_W'(3): r = CW'(133525159);
            STAGE_W'(4): r = CW'(67021687);
            STAGE_W'(5): r = CW'(33543516);
            STAGE_W'(6): r = CW'(16775851);
            STAGE_W'(7): r = CW'(8388437);
            STAGE_W'(8): r = CW'(4194283);
            STAGE_W'(9): r = CW'(2097149);
            default:     r = CW'(ONE_Q30 >> i);
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/astroid_point_and_arc_length_core.sv
// Top level: angle to quadrant and radians, CORDIC cell chain, cube and length stages.
// Depends on acl_pkg and acl_cordic_cell.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    angle
// out      output     out_valid / out_stall  point_x, point_y, arc_length
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One angle per cycle while no result waits under out_stall.
// The whole pipeline holds while a result waits under out_stall; in_stall follows.
// Reset clears the configuration, front and cell chain registers and all stage valids; stage data has no reset.
module astroid_point_and_arc_length_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] point_x,
    output logic signed [17:0] point_y,
    output logic [18:0]        arc_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int NS = acl_pkg::CORDIC_STAGES;
    localparam int PW = acl_pkg::PHASE_W + 31;

    logic [15:0] radius_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic        adv;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                acl_pkg::REG_RADIUS:   radius_reg   <= cfg_data;
                acl_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                acl_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // front: quadrant and phase in radians
    logic [acl_pkg::ANGLE_BITS-1:0] a_ext;
    logic [acl_pkg::PHASE_W-1:0]    phase;
    logic [PW-1:0]                  prod;
    acl_pkg::cell_t                 front_next;
    acl_pkg::cell_t                 chain [0:NS];

    always_comb
    begin
        a_ext = acl_pkg::ANGLE_BITS'(angle);
        phase = a_ext[acl_pkg::PHASE_W-1:0];
        prod  = PW'(phase) * PW'(acl_pkg::HALF_PI_Q30)
              + (PW'(1) << (acl_pkg::PHASE_W - 1));
        front_next.valid = in_valid;
        front_next.quad  = a_ext[acl_pkg::ANGLE_BITS-1 -: 2];
        front_next.x     = acl_pkg::GAIN_Q30;
        front_next.y     = '0;
        front_next.z     = acl_pkg::CW'(prod >> acl_pkg::PHASE_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain[0] <= '0;
        else if (adv)
            chain[0] <= front_next;
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        acl_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .idx   (acl_pkg::STAGE_W'(g)),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // stage 1: clamp and quadrant map
    logic [30:0] c_cl, s_cl;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic [30:0] s1_magx_reg, s1_magy_reg, s1_s_reg;
    logic        s1_negx_reg, s1_negy_reg;
    logic [1:0]  s1_quad_reg;
    logic [30:0] s1_magx_next, s1_magy_next;
    logic        s1_negx_next, s1_negy_next;

    function automatic logic [30:0] clamp_q30(input logic signed [acl_pkg::CW-1:0] v);
        logic [30:0] r;
        if (v[acl_pkg::CW-1])
            r = '0;
        else if (v > $signed(acl_pkg::ONE_Q30))
            r = 31'(acl_pkg::ONE_Q30);
        else
            r = v[30:0];
        return r;
    endfunction

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [62:0] p;
        p = 63'(a) * 63'(b) + (63'(1) << 29);
        return 31'(p >> 30);
    endfunction

    always_comb
    begin
        c_cl = clamp_q30(chain[NS].x);
        s_cl = clamp_q30(chain[NS].y);
        unique case (chain[NS].quad)
            2'd0:
            begin
                s1_magx_next = c_cl; s1_negx_next = 1'b0;
                s1_magy_next = s_cl; s1_negy_next = 1'b0;
            end
            2'd1:
            begin
                s1_magx_next = s_cl; s1_negx_next = 1'b1;
                s1_magy_next = c_cl; s1_negy_next = 1'b0;
            end
            2'd2:
            begin
                s1_magx_next = c_cl; s1_negx_next = 1'b1;
                s1_magy_next = s_cl; s1_negy_next = 1'b1;
            end
            default:
            begin
                s1_magx_next = s_cl; s1_negx_next = 1'b0;
                s1_magy_next = c_cl; s1_negy_next = 1'b1;
            end
        endcase
    end

    logic [30:0] s2_sqx_reg, s2_sqy_reg, s2_ss_reg, s2_magx_reg, s2_magy_reg;
    logic        s2_negx_reg, s2_negy_reg, s3_negx_reg, s3_negy_reg;
    logic        s4_negx_reg, s4_negy_reg;
    logic [1:0]  s2_quad_reg, s3_quad_reg;
    logic [30:0] s3_cubex_reg, s3_cubey_reg;
    logic [48:0] s3_lenf_reg;
    logic [16:0] s4_scx_reg, s4_scy_reg;
    logic [18:0] s4_len_reg;
    logic [45:0] scx_p, scy_p;
    logic [49:0] len_sum;
    logic [19:0] len_r;
    logic signed [18:0] px_sum, py_sum;
    logic signed [17:0] px_reg, py_reg;
    logic [18:0]        len_out_reg;

    function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v > 19'sd131071)
            r = 18'sd131071;
        else if (v < -19'sd131072)
            r = -18'sd131072;
        else
            r = v[17:0];
        return r;
    endfunction

    always_comb
    begin
        scx_p   = 46'(radius_reg) * 46'(s3_cubex_reg) + (46'(1) << 29);
        scy_p   = 46'(radius_reg) * 46'(s3_cubey_reg) + (46'(1) << 29);
        len_sum = ((50'(radius_reg) * 50'd3 * 50'(s3_quad_reg)) << 29)
                + 50'(s3_lenf_reg >> 1) + (50'(1) << 29);
        len_r   = 20'(len_sum >> 30);
        px_sum  = (s4_negx_reg ? -$signed({2'b00, s4_scx_reg}) : $signed({2'b00, s4_scx_reg}))
                + 19'($signed(center_x_reg));
        py_sum  = (s4_negy_reg ? -$signed({2'b00, s4_scy_reg}) : $signed({2'b00, s4_scy_reg}))
                + 19'($signed(center_y_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= chain[NS].valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_magx_reg  <= s1_magx_next;
            s1_magy_reg  <= s1_magy_next;
            s1_negx_reg  <= s1_negx_next;
            s1_negy_reg  <= s1_negy_next;
            s1_s_reg     <= s_cl;
            s1_quad_reg  <= chain[NS].quad;

            s2_sqx_reg   <= mul_q30(s1_magx_reg, s1_magx_reg);
            s2_sqy_reg   <= mul_q30(s1_magy_reg, s1_magy_reg);
            s2_ss_reg    <= mul_q30(s1_s_reg, s1_s_reg);
            s2_magx_reg  <= s1_magx_reg;
            s2_magy_reg  <= s1_magy_reg;
            s2_negx_reg  <= s1_negx_reg;
            s2_negy_reg  <= s1_negy_reg;
            s2_quad_reg  <= s1_quad_reg;

            s3_cubex_reg <= mul_q30(s2_sqx_reg, s2_magx_reg);
            s3_cubey_reg <= mul_q30(s2_sqy_reg, s2_magy_reg);
            s3_lenf_reg  <= 49'(radius_reg) * 49'd3 * 49'(s2_ss_reg);
            s3_negx_reg  <= s2_negx_reg;
            s3_negy_reg  <= s2_negy_reg;
            s3_quad_reg  <= s2_quad_reg;

            s4_scx_reg   <= 17'(scx_p >> 30);
            s4_scy_reg   <= 17'(scy_p >> 30);
            s4_len_reg   <= (len_r > 20'd524287) ? 19'd524287 : len_r[18:0];
            s4_negx_reg  <= s3_negx_reg;
            s4_negy_reg  <= s3_negy_reg;

            px_reg       <= sat18(px_sum);
            py_reg       <= sat18(py_sum);
            len_out_reg  <= s4_len_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign arc_length = len_out_reg;

endmodule

### hw/rtl/acl_cordic_cell.sv
// One CORDIC rotation cell: rotate by the arctangent table entry for its stage index, direction set by the sign of z.
// Depends on acl_pkg for the cell record and the arctangent table.
module acl_cordic_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [acl_pkg::STAGE_W-1:0] idx,
    input  acl_pkg::cell_t              din,
    output acl_pkg::cell_t              dout
);

    acl_pkg::cell_t d_reg;
    acl_pkg::cell_t d_next;
    logic signed [acl_pkg::CW-1:0] dx;
    logic signed [acl_pkg::CW-1:0] dy;
    logic signed [acl_pkg::CW-1:0] da;

    always_comb
    begin
        dx = din.y >>> idx;
        dy = din.x >>> idx;
        da = acl_pkg::atan_q30(idx);
        d_next       = din;
        if (!din.z[acl_pkg::CW-1])
        begin
            d_next.x = din.x - dx;
            d_next.y = din.y + dy;
            d_next.z = din.z - da;
        end
        else
        begin
            d_next.x = din.x + dx;
            d_next.y = din.y - dy;
            d_next.z = din.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (adv)
            d_reg <= d_next;
    end

    assign dout = d_reg;

endmodule

### hw/rtl/acl_checker.sv
// Port-level checks for the astroid point and arc length core, bound to the top.
// Depends only on the top level's ports.
module acl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [17:0] point_x,
    input logic signed [17:0] point_y,
    input logic [18:0]        arc_length,
    input logic               cfg_ready
);

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow a blocked output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(arc_length))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port refused a transfer");

endmodule

bind astroid_point_and_arc_length_core acl_checker u_acl_checker (.*);

### test/tb_top.sv
// Testbench for the astroid point and arc length core: random and directed angles,
// register writes between phases, results checked against an in-bench predictor.
// Depends on acl_pkg and astroid_point_and_arc_length_core.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [18:0]        len;
    } curve_pt_t;

    localparam int         DRAIN_CYCLES = acl_pkg::CORDIC_STAGES + 12;
    localparam int         STALL_LIMIT  = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        angle;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] point_x;
    logic signed [17:0] point_y;
    logic [18:0]        arc_length;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    logic [15:0] pending_angles[$];
    curve_pt_t   expected_pts[$];
    logic [15:0] cur_radius;
    logic [15:0] cur_cx;
    logic [15:0] cur_cy;
    int          fail_count;
    int          idle_cycles;
    bit          gaps_on;
    bit          stim_done;

    astroid_point_and_arc_length_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .angle      (angle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .arc_length (arc_length),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint arctan_q30(int i);
        longint unsigned acc;
        longint unsigned term;
        if (i == 0)
            return 843314857;
        acc = 0;
        for (int n = 0; (2 * n + 1) * i <= 60; n++)
        begin
            term = (64'd1 << (60 - (2 * n + 1) * i)) / (2 * n + 1);
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    function automatic logic signed [17:0] cube_coord(longint v, logic [15:0] ctr);
        longint unsigned mag;
        longint unsigned cube;
        longint          scaled;
        longint          r;
        mag = (v < 0) ? -v : v;
        cube = q30_mul(q30_mul(mag, mag), mag);
        scaled = longint'((longint'(cur_radius) * cube + (64'd1 << 29)) >> 30);
        r = ((v < 0) ? -scaled : scaled) + longint'($signed(ctr));
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[17:0];
    endfunction

    function automatic curve_pt_t astroid_point(logic [15:0] ang);
        curve_pt_t       p;
        logic [1:0]      quad;
        longint unsigned phase;
        longint unsigned len;
        longint          z;
        longint          cx;
        longint          sy;
        longint          dx;
        longint          dy;
        longint          c;
        longint          s;
        longint          cs;
        longint          sn;
        quad = ang[15:14];
        phase = 64'(ang[13:0]);
        z = longint'((phase * 64'd1686629713 + 64'd8192) >> 14);
        cx = 652032874;
        sy = 0;
        for (int i = 0; i < acl_pkg::CORDIC_STAGES; i++)
        begin
            dx = asr(sy, i);
            dy = asr(cx, i);
            if (z >= 0)
            begin
                cx -= dx;
                sy += dy;
                z -= arctan_q30(i);
            end
            else
            begin
                cx += dx;
                sy -= dy;
                z += arctan_q30(i);
            end
        end
        c = (cx < 0) ? 0 : (cx > 1073741824) ? 1073741824 : cx;
        s = (sy < 0) ? 0 : (sy > 1073741824) ? 1073741824 : sy;
        case (quad)
            2'd0:    begin cs = c;  sn = s;  end
            2'd1:    begin cs = -s; sn = c;  end
            2'd2:    begin cs = -c; sn = -s; end
            default: begin cs = s;  sn = -c; end
        endcase
        p.x = cube_coord(cs, cur_cx);
        p.y = cube_coord(sn, cur_cy);
        len = ((64'd3 * 64'(cur_radius) * 64'(quad)) << 29)
            + ((64'd3 * 64'(cur_radius) * q30_mul(s, s)) >> 1);
        len = (len + (64'd1 << 29)) >> 30;
        if (len > 524287)
            len = 524287;
        p.len = len[18:0];
        return p;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            acl_pkg::REG_RADIUS:   cur_radius = val;
            acl_pkg::REG_CENTER_X: cur_cx = val;
            default:               cur_cy = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_angles.size() != 0 || in_valid || expected_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_angles(int n);
        for (int i = 0; i < n; i++)
            pending_angles.push_back(16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            angle    <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_pts.push_back(astroid_point(angle));
            if (pending_angles.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 26))
            begin
                in_valid <= 1'b1;
                angle    <= pending_angles.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pts.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d len=%0d", point_x, point_y,
                        arc_length);
                    fail_count++;
                end
                else
                begin
                    curve_pt_t e;
                    e = expected_pts.pop_front();
                    if (point_x !== e.x)
                    begin
                        $error("point_x expected %0d actual %0d", e.x, point_x);
                        fail_count++;
                    end
                    if (point_y !== e.y)
                    begin
                        $error("point_y expected %0d actual %0d", e.y, point_y);
                        fail_count++;
                    end
                    if (arc_length !== e.len)
                    begin
                        $error("arc_length expected %0d actual %0d", e.len, arc_length);
                        fail_count++;
                    end
                end
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 26);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready) || (stim_done && expected_pts.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [15:0] corner_angles[$];
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cur_radius = '0;
        cur_cx     = '0;
        cur_cy     = '0;
        fail_count = 0;
        idle_cycles = 0;
        gaps_on    = 1'b1;
        stim_done  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero radius: point is the center, length zero
        pending_angles.push_back(16'h0000);
        pending_angles.push_back(16'h5555);
        wait_idle();

        write_reg(acl_pkg::REG_RADIUS, 16'hFFFF);
        write_reg(acl_pkg::REG_CENTER_X, 16'h7FFF);
        write_reg(acl_pkg::REG_CENTER_Y, 16'h8000);
        corner_angles = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
                          16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF,
                          16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h5555, 16'hAAAA};
        foreach (corner_angles[i])
            pending_angles.push_back(corner_angles[i]);
        wait_idle();

        write_reg(acl_pkg::REG_CENTER_X, 16'h8000);
        write_reg(acl_pkg::REG_CENTER_Y, 16'h7FFF);
        random_angles(150);
        wait_idle();

        write_reg(acl_pkg::REG_RADIUS, 16'h0100);
        write_reg(acl_pkg::REG_CENTER_X, 16'h0000);
        write_reg(acl_pkg::REG_CENTER_Y, 16'h0000);
        gaps_on = 1'b0;
        random_angles(200);
        wait_idle();
        gaps_on = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(acl_pkg::REG_RADIUS, 16'($urandom_range(0, 65535)));
            write_reg(acl_pkg::REG_CENTER_X, 16'($urandom_range(0, 65535)));
            write_reg(acl_pkg::REG_CENTER_Y, 16'($urandom_range(0, 65535)));
            random_angles(120);
            wait_idle();
        end

        write_reg(acl_pkg::REG_RADIUS, 16'h0001);
        random_angles(20);
        stim_done = 1'b1;
        wait_idle();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/acl_pkg.sv
hw/rtl/acl_cordic_cell.sv
hw/rtl/astroid_point_and_arc_length_core.sv
hw/rtl/acl_checker.sv
test/tb_top.sv
